// ===== design/hsvsrgb_pkg.sv =====
`default_nettype none

package hsvsrgb_pkg;

  localparam int HUE_BITS_DEF = 12;
  localparam int LIN_BITS_DEF = 12;
  localparam int HUE_W        = 12;
  localparam int CH_W         = 8;
  localparam int NCH          = 3;
  localparam int IN_W         = 32;
  localparam int OUT_W        = 24;
  localparam int DEN_C        = 65025;
  localparam int THR_W        = 16;
  localparam int CODE_N       = 256;
  localparam int SEARCH_N     = 8;

  typedef logic [THR_W-1:0] thr_tab_t [CODE_N];

  // Smallest linear index that encodes to at least each code; unreached codes get 2^lin_bits.
  function automatic thr_tab_t srgb_thr(input int lin_bits);
    thr_tab_t     tab;
    logic [255:0] code_lim [CODE_N];
    logic [255:0] k12;
    logic [255:0] lmax5;
    logic [255:0] acc;
    longint       num;
    longint       den;
    int           lin_max;
    int           lo;
    int           hi;
    int           mid;
    int           code;
    int           idx;
    int           blk;
    int           sub;
    int           c;
    int           n;
    lin_max = (1 << lin_bits) - 1;
    k12     = 256'(1);
    lmax5   = 256'(1);
    for (n = 0; n < 12; n++) k12 = k12 * 256'(10761);
    for (n = 0; n < 5; n++) lmax5 = lmax5 * 256'(lin_max);
    code_lim[0] = '0;
    for (c = 1; c < CODE_N; c++) begin
      acc = 256'(1);
      for (n = 0; n < 12; n++) acc = acc * 256'(40 * c + 541);
      code_lim[c] = acc * lmax5;
    end
    for (c = 0; c < CODE_N; c++) tab[c] = THR_W'(lin_max + 1);
    tab[0] = '0;
    for (blk = 0; blk < ((lin_max + 1) >> 6); blk++) begin
      for (sub = 0; sub < 64; sub++) begin
        idx  = (blk << 6) + sub;
        code = 0;
        if (longint'(idx) * 64'd10000000 < longint'(31308) * longint'(lin_max)) begin
          num = longint'(idx) * 64'd658920 + 64'd100 * longint'(lin_max);
          den = 64'd200 * longint'(lin_max);
          for (c = 1; c < CODE_N; c++) begin
            if (longint'(c) * den <= num) code = c;
          end
        end else begin
          acc = k12;
          for (n = 0; n < 5; n++) acc = acc * 256'(idx);
          lo = 0;
          hi = CODE_N - 1;
          for (n = 0; n < SEARCH_N; n++) begin
            if (lo < hi) begin
              mid = (lo + hi + 1) >> 1;
              if (acc >= code_lim[mid]) lo = mid;
              else hi = mid - 1;
            end
          end
          code = lo;
        end
        for (c = 1; c <= code; c++) begin
          if (tab[c] == THR_W'(lin_max + 1)) tab[c] = THR_W'(idx);
        end
      end
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// ===== design/hsv_to_srgb_pixel.sv =====
`default_nettype none

// Channel  Direction  tdata fields (lowest bit up)
// in_      slave      hue[11:0], saturation[19:12], brightness[27:20], zero[31:28]
// out_     master     red[7:0], green[15:8], blue[23:16]
//
// One transfer per cycle in and out while the output is not stalled, through eight
// arithmetic stages (phase, triangle, saturation mix, brightness scale, rounding,
// two-stage reciprocal divide and its correction) and the eight-step threshold search.
// Reset clears the stage valid bits only; the encode thresholds are constants.
// Each stage advances when it is empty or any later stage can take data, so bubbles
// close up under a stalled output.

module hsv_to_srgb_pixel #(
  parameter int HUE_BITS = hsvsrgb_pkg::HUE_BITS_DEF,
  parameter int LIN_BITS = hsvsrgb_pkg::LIN_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [hsvsrgb_pkg::IN_W-1:0]  in_tdata,   // hue, saturation, brightness
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [hsvsrgb_pkg::OUT_W-1:0] out_tdata   // red, green, blue
);

  import hsvsrgb_pkg::*;

  localparam int HB   = HUE_BITS;
  localparam int LB   = LIN_BITS;
  localparam int AW   = LB + 16;
  localparam int W5   = HB + AW + 1;
  localparam int RW   = LB + 1;
  localparam int NST  = 8 + SEARCH_N;
  localparam int OFF_G = ((4 << HB) + 3) / 6;
  localparam int OFF_B = ((2 << HB) + 3) / 6;
  localparam longint unsigned RECIP = (64'd1 << AW) / DEN_C;
  localparam thr_tab_t THR = srgb_thr(LIN_BITS);

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  logic [HUE_W-1:0] in_hue;
  logic [CH_W-1:0]  in_sat;
  logic [CH_W-1:0]  in_bri;
  logic [HB-1:0]    hue_h;

  logic [CH_W-1:0]  s0_sat_r, s0_bri_r, s1_sat_r, s1_bri_r, s2_bri_r;
  logic [HB-1:0]    s0_p_r    [NCH];
  logic [HB:0]      s1_t_r    [NCH];
  logic [HB+7:0]    s2_mix_r  [NCH];
  logic [HB+15:0]   s3_num_r  [NCH];
  logic [AW-1:0]    s4_a_r    [NCH];
  logic [LB-1:0]    s5_est_r  [NCH];
  logic [AW-1:0]    s5_a_r    [NCH];
  logic [LB-1:0]    s6_est_r  [NCH];
  logic [AW-1:0]    s6_a_r    [NCH];
  logic [AW-1:0]    s6_prod_r [NCH];
  logic [LB-1:0]    s7_idx_r  [NCH];
  logic [CH_W-1:0]  sc_code_r [SEARCH_N][NCH];
  logic [LB-1:0]    sc_idx_r  [SEARCH_N-1][NCH];

  assign in_hue = in_tdata[HUE_W-1:0];
  assign in_sat = in_tdata[HUE_W +: CH_W];
  assign in_bri = in_tdata[HUE_W+CH_W +: CH_W];
  assign hue_h  = HB'(in_hue);

  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = out_tready || !(&v_r[NST-1:k]);
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_sat_r <= in_sat;
      s0_bri_r <= in_bri;
    end
    if (en[1]) begin
      s1_sat_r <= s0_sat_r;
      s1_bri_r <= s0_bri_r;
    end
    if (en[2]) begin
      s2_bri_r <= s1_bri_r;
    end
  end

  for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
    localparam int OFF = (ch == 0) ? 0 : ((ch == 1) ? OFF_G : OFF_B);

    logic [HB-1:0]   p_nxt;
    logic [HB+2:0]   six_p;
    logic [HB+2:0]   absd;
    logic [HB:0]     t_nxt;
    logic [HB:0]     w;
    logic [HB+8:0]   mix_full;
    logic [HB+7:0]   mix_nxt;
    logic [HB+15:0]  num_nxt;
    logic [W5-1:0]   q2;
    logic [AW-1:0]   a_nxt;
    logic [AW+RW-1:0] rprod;
    logic [LB-1:0]   est_nxt;
    logic [AW-1:0]   prod_nxt;
    logic            fix;
    logic [LB-1:0]   idx_nxt;

    always_comb begin
      p_nxt = hue_h + HB'(OFF);

      six_p = (HB+3)'(s0_p_r[ch]) * (HB+3)'(6);
      if (six_p >= ((HB+3)'(3) << HB)) absd = six_p - ((HB+3)'(3) << HB);
      else absd = ((HB+3)'(3) << HB) - six_p;
      priority if (absd <= ((HB+3)'(1) << HB)) t_nxt = '0;
      else if (absd >= ((HB+3)'(2) << HB)) t_nxt = (HB+1)'(1) << HB;
      else t_nxt = (HB+1)'(absd - ((HB+3)'(1) << HB));

      w        = ((HB+1)'(1) << HB) - s1_t_r[ch];
      mix_full = ((HB+9)'(255) << HB) - (HB+9)'(w) * (HB+9)'(s1_sat_r);
      mix_nxt  = mix_full[HB+7:0];

      num_nxt = (HB+16)'(s2_bri_r) * (HB+16)'(s2_mix_r[ch]);

      q2    = (W5'(s3_num_r[ch]) << (LB + 1)) - (W5'(s3_num_r[ch]) << 1)
              + (W5'(DEN_C) << HB);
      a_nxt = q2[HB+1 +: AW];

      rprod   = (AW+RW)'(s4_a_r[ch]) * (AW+RW)'(RECIP);
      est_nxt = rprod[AW +: LB];

      prod_nxt = AW'(s5_est_r[ch]) * AW'(DEN_C);

      fix     = (AW+1)'(s6_a_r[ch]) >= ((AW+1)'(s6_prod_r[ch]) + (AW+1)'(DEN_C));
      idx_nxt = s6_est_r[ch] + LB'(fix);
    end

    always_ff @(posedge clk) begin
      if (en[0]) s0_p_r[ch]   <= p_nxt;
      if (en[1]) s1_t_r[ch]   <= t_nxt;
      if (en[2]) s2_mix_r[ch] <= mix_nxt;
      if (en[3]) s3_num_r[ch] <= num_nxt;
      if (en[4]) s4_a_r[ch]   <= a_nxt;
      if (en[5]) begin
        s5_est_r[ch] <= est_nxt;
        s5_a_r[ch]   <= s4_a_r[ch];
      end
      if (en[6]) begin
        s6_est_r[ch]  <= s5_est_r[ch];
        s6_a_r[ch]    <= s5_a_r[ch];
        s6_prod_r[ch] <= prod_nxt;
      end
      if (en[7]) s7_idx_r[ch] <= idx_nxt;
    end

    for (genvar k = 0; k < SEARCH_N; k++) begin : g_srch
      logic [CH_W-1:0] code_in;
      logic [LB-1:0]   idx_in;
      logic [CH_W-1:0] cand;
      logic [CH_W-1:0] code_nxt;

      if (k == 0) begin : g_first
        assign code_in = '0;
        assign idx_in  = s7_idx_r[ch];
      end else begin : g_next
        assign code_in = sc_code_r[k-1][ch];
        assign idx_in  = sc_idx_r[k-1][ch];
      end

      always_comb begin
        cand     = code_in | (CH_W'(1) << (SEARCH_N - 1 - k));
        code_nxt = (THR_W'(idx_in) >= THR[cand]) ? cand : code_in;
      end

      always_ff @(posedge clk) begin
        if (en[8+k]) sc_code_r[k][ch] <= code_nxt;
      end

      if (k < SEARCH_N - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en[8+k]) sc_idx_r[k][ch] <= idx_in;
        end
      end
    end

    assign out_tdata[ch*CH_W +: CH_W] = sc_code_r[SEARCH_N-1][ch];
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted transfer did not enter the pipeline");

  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !v_r[NST-2] |=> !out_tvalid)
    else $error("result repeated after transfer");

  for (genvar ch = 0; ch < NCH; ch++) begin : g_chk
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
      v_r[6] |-> (s6_a_r[ch] >= s6_prod_r[ch])
                 && ((s6_a_r[ch] - s6_prod_r[ch]) < AW'(2 * DEN_C)))
      else $error("reciprocal quotient estimate out of range");
  end

endmodule

`default_nettype wire
